// ===== rtl/ppdc_pkg.sv =====
// ----------------------------------------------------------------------------
// ppdc_pkg
// Shared widths, register indexes, stage records and step functions for the
// periodic pair distance and direction cosine pipeline.
// ----------------------------------------------------------------------------
package ppdc_pkg;

  localparam int CW       = 24;              // coordinate width, unsigned
  localparam int OW       = CW + 2;          // signed image offset
  localparam int SW       = 2 * CW;          // squared magnitude
  localparam int AW       = SW + 2;          // sum of three squares
  localparam int NIMG     = 27;
  localparam int IDXW     = 5;
  localparam int OPEN_IMG = 13;              // image (1,1,1), the direct offset
  localparam int CSH      = 15;              // Q1.15 scale
  localparam int QW       = CSH + 2;         // quotient bits, up to 2^15
  localparam int NW       = CW + CSH + 1;    // rounded numerator
  localparam int COSW     = 16;
  localparam int IN_W     = ((6 * CW + 7) / 8) * 8;
  localparam int OUT_W    = ((CW + 3 * COSW + 7) / 8) * 8;
  localparam int USER_W   = 6;
  localparam int CFG_IW   = 3;

  localparam logic [CFG_IW-1:0] REG_PERIODIC = 3'd0;
  localparam logic [CFG_IW-1:0] REG_CELL_X   = 3'd1;
  localparam logic [CFG_IW-1:0] REG_CELL_Y   = 3'd2;
  localparam logic [CFG_IW-1:0] REG_CELL_Z   = 3'd3;
  localparam logic [CFG_IW-1:0] REG_CUTOFF   = 3'd4;

  localparam logic [QW-1:0] COS_POS_MAX = QW'(32767);
  localparam logic [QW-1:0] COS_NEG_MAX = QW'(32768);

  typedef struct packed {
    logic              periodic;
    logic [2:0][CW-1:0] cell_len;
    logic [CW-1:0]      cutoff;
  } cfg_t;

  // One pair after the window test: a pass mask over the 27 images.
  typedef struct packed {
    logic [NIMG-1:0]          mask;
    logic [NIMG-1:0][SW-1:0]  sum;
    logic [2:0][2:0][CW-1:0]  mag;
    logic [2:0][2:0]          neg;
  } pair_t;

  // One passing image on its way to the square root.
  typedef struct packed {
    logic [SW-1:0]       s;
    logic [2:0][CW-1:0]  mag;
    logic [2:0]          neg;
    logic [2:0][1:0]     img;
    logic                last;
  } cand_t;

  typedef struct packed {
    logic [SW-1:0]       v;
    logic [CW:0]         rem;
    logic [CW-1:0]       root;
    logic [2:0][CW-1:0]  mag;
    logic [2:0]          neg;
    logic [2:0][1:0]     img;
    logic                last;
  } sq_t;

  typedef struct packed {
    logic [CW-1:0]       dist_res;
    logic                zero;
    logic [2:0][QW-1:0]  n;
    logic [2:0][CW-1:0]  rem;
    logic [2:0][QW-1:0]  q;
    logic [2:0]          neg;
    logic [2:0][1:0]     img;
    logic                last;
  } dv_t;

  typedef struct packed {
    logic [CW-1:0]        dist_res;
    logic [2:0][COSW-1:0] cosv;
    logic [2:0][1:0]      img;
    logic                 last;
  } rec_t;

  // One bit of the digit-by-digit integer square root.
  function automatic sq_t sqrt_step(sq_t a);
    sq_t         o;
    logic [CW+2:0] remsh;
    logic [CW+2:0] t;
    logic [CW+2:0] diff;
    o     = a;
    remsh = {a.rem, a.v[SW-1 -: 2]};
    t     = {1'b0, a.root, 2'b01};
    diff  = remsh - t;
    if (remsh >= t) begin
      o.rem  = diff[CW:0];
      o.root = {a.root[CW-2:0], 1'b1};
    end else begin
      o.rem  = remsh[CW:0];
      o.root = {a.root[CW-2:0], 1'b0};
    end
    o.v = {a.v[SW-3:0], 2'b00};
    return o;
  endfunction

  // One quotient bit of the three restoring dividers.
  function automatic dv_t div_step(dv_t a);
    dv_t         o;
    logic [CW:0] remsh;
    logic [CW:0] dd;
    logic [CW:0] diff;
    logic        ge;
    o  = a;
    dd = {1'b0, a.dist_res};
    for (int k = 0; k < 3; k++) begin
      remsh = {a.rem[k], a.n[k][QW-1]};
      diff  = remsh - dd;
      ge    = (remsh >= dd);
      o.rem[k] = ge ? diff[CW-1:0] : remsh[CW-1:0];
      o.q[k]   = {a.q[k][QW-2:0], ge};
      o.n[k]   = {a.n[k][QW-2:0], 1'b0};
    end
    return o;
  endfunction

  // Signs and saturates a rounded quotient into Q1.15.
  function automatic logic [COSW-1:0] cos_fmt(logic [QW-1:0] q, logic neg, logic zero);
    logic [QW-1:0] m;
    logic [COSW-1:0] r;
    m = q;
    if (zero) begin
      r = '0;
    end else if (neg) begin
      if (m > COS_NEG_MAX) m = COS_NEG_MAX;
      r = COSW'(-m);
    end else begin
      if (m > COS_POS_MAX) m = COS_POS_MAX;
      r = m[COSW-1:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/ppdc_front.sv =====
// ----------------------------------------------------------------------------
// ppdc_front
// Five-stage window test: offsets, image magnitudes, squares, sums, compare.
// ----------------------------------------------------------------------------
module ppdc_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  ppdc_pkg::cfg_t            cfg,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [ppdc_pkg::IN_W-1:0] in_tdata,
  output logic                      pair_valid,
  input  logic                      pair_ready,
  output ppdc_pkg::pair_t           pair
);
  import ppdc_pkg::*;

  logic [4:0] v_r;
  logic [5:0] rdy;

  logic [2:0][CW:0]          d_r, d_nxt;
  logic [2:0][2:0][CW-1:0]   magb_r, magb_nxt, magc_r, magd_r;
  logic [2:0][2:0]           negb_r, negb_nxt, negc_r, negd_r;
  logic [2:0][2:0]           okb_r, okb_nxt, okc_r;
  logic [2:0][2:0][SW-1:0]   sq_r, sq_nxt;
  logic [NIMG-1:0][AW-1:0]   sum_r, sum_nxt;
  logic [NIMG-1:0]           okd_r, okd_nxt;
  logic [SW-1:0]             lim_r;
  pair_t                     pair_r, pair_nxt;

  assign rdy[5] = pair_ready;
  always_comb begin
    for (int k = 4; k >= 0; k--) rdy[k] = !v_r[k] || rdy[k+1];
  end
  assign in_tready  = rdy[0];
  assign pair_valid = v_r[4];
  assign pair       = pair_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) v_r[0] <= in_tvalid;
      for (int k = 1; k < 5; k++) begin
        if (rdy[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    lim_r <= cfg.cutoff * cfg.cutoff;
  end

  // Stage A: direct offsets b - a.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      d_nxt[k] = {1'b0, in_tdata[(k+3)*CW +: CW]} - {1'b0, in_tdata[k*CW +: CW]};
    end
  end

  // Stage B: the three image offsets per axis, their magnitudes and cutoff test.
  always_comb begin
    logic [OW-1:0] de, le, off, ab;
    for (int k = 0; k < 3; k++) begin
      de = {d_r[k][CW], d_r[k]};
      le = {2'b00, cfg.cell_len[k]};
      for (int i = 0; i < 3; i++) begin
        off = (i == 0) ? de - le : (i == 1) ? de : de + le;
        ab  = off[OW-1] ? -off : off;
        negb_nxt[k][i] = off[OW-1];
        magb_nxt[k][i] = ab[CW-1:0];
        okb_nxt[k][i]  = (ab <= {2'b00, cfg.cutoff});
      end
    end
  end

  // Stage C: nine squares.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 3; i++) sq_nxt[k][i] = magb_r[k][i] * magb_r[k][i];
    end
  end

  // Stage D: 27 sums, ordered x outer, z inner.
  always_comb begin
    int n;
    for (int u = 0; u < 3; u++) begin
      for (int v = 0; v < 3; v++) begin
        for (int w = 0; w < 3; w++) begin
          n = u * 9 + v * 3 + w;
          sum_nxt[n] = {2'b00, sq_r[0][u]} + {2'b00, sq_r[1][v]} + {2'b00, sq_r[2][w]};
          okd_nxt[n] = okc_r[0][u] && okc_r[1][v] && okc_r[2][w];
        end
      end
    end
  end

  // Stage E: compare against cutoff squared.
  always_comb begin
    pair_nxt.mag = magd_r;
    pair_nxt.neg = negd_r;
    for (int n = 0; n < NIMG; n++) begin
      pair_nxt.sum[n]  = sum_r[n][SW-1:0];
      pair_nxt.mask[n] = (cfg.periodic || n == OPEN_IMG) && okd_r[n] &&
                         (sum_r[n] <= {2'b00, lim_r});
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) d_r <= d_nxt;
    if (rdy[1]) begin
      magb_r <= magb_nxt;
      negb_r <= negb_nxt;
      okb_r  <= okb_nxt;
    end
    if (rdy[2]) begin
      sq_r   <= sq_nxt;
      magc_r <= magb_r;
      negc_r <= negb_r;
      okc_r  <= okb_r;
    end
    if (rdy[3]) begin
      sum_r  <= sum_nxt;
      okd_r  <= okd_nxt;
      magd_r <= magc_r;
      negd_r <= negc_r;
    end
    if (rdy[4]) pair_r <= pair_nxt;
  end

endmodule

// ===== rtl/ppdc_pick.sv =====
// ----------------------------------------------------------------------------
// ppdc_pick
// Holds a tested pair, handing out its passing images one per cycle while en.
// ----------------------------------------------------------------------------
module ppdc_pick (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            pair_valid,
  output logic            pair_ready,
  input  ppdc_pkg::pair_t pair,
  input  logic            en,
  output logic            cand_valid,
  output ppdc_pkg::cand_t cand
);
  import ppdc_pkg::*;

  logic            held_r;
  pair_t           pair_r;
  logic            found;
  logic [IDXW-1:0] idx;
  logic [2:0][1:0] sel;
  logic [NIMG-1:0] rest;
  logic            done;

  always_comb begin
    found = 1'b0;
    idx   = '0;
    sel   = '0;
    for (int u = 0; u < 3; u++) begin
      for (int v = 0; v < 3; v++) begin
        for (int w = 0; w < 3; w++) begin
          if (!found && pair_r.mask[u*9 + v*3 + w]) begin
            found  = 1'b1;
            idx    = IDXW'(u*9 + v*3 + w);
            sel[0] = 2'(u);
            sel[1] = 2'(v);
            sel[2] = 2'(w);
          end
        end
      end
    end
    rest      = pair_r.mask;
    rest[idx] = 1'b0;
  end

  always_comb begin
    cand.s    = pair_r.sum[idx];
    cand.img  = sel;
    cand.last = (rest == '0);
    for (int k = 0; k < 3; k++) begin
      cand.mag[k] = pair_r.mag[k][sel[k]];
      cand.neg[k] = pair_r.neg[k][sel[k]];
    end
  end

  assign cand_valid = held_r && found;
  assign done       = held_r && (!found || (en && rest == '0));
  assign pair_ready = !held_r || done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= 1'b0;
    end else if (pair_ready) begin
      held_r <= pair_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pair_ready && pair_valid) begin
      pair_r <= pair;
    end else if (held_r && en && found) begin
      pair_r.mask <= rest;
    end
  end

endmodule

// ===== rtl/ppdc_sqrt.sv =====
// ----------------------------------------------------------------------------
// ppdc_sqrt
// Square root pipeline, one root bit per stage.
// ----------------------------------------------------------------------------
module ppdc_sqrt (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            cand_valid,
  input  ppdc_pkg::cand_t cand,
  output logic            sq_valid,
  output ppdc_pkg::sq_t   sq
);
  import ppdc_pkg::*;

  logic [CW:0] v_r;
  sq_t         st_r [0:CW];
  sq_t         first;

  always_comb begin
    first.v    = cand.s;
    first.rem  = '0;
    first.root = '0;
    first.mag  = cand.mag;
    first.neg  = cand.neg;
    first.img  = cand.img;
    first.last = cand.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[CW-1:0], cand_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r[0] <= first;
      for (int i = 0; i < CW; i++) st_r[i+1] <= sqrt_step(st_r[i]);
    end
  end

  assign sq_valid = v_r[CW];
  assign sq       = st_r[CW];

endmodule

// ===== rtl/ppdc_div.sv =====
// ----------------------------------------------------------------------------
// ppdc_div
// Three dividers in lockstep, one quotient bit per stage, then the output
// record register.
// ----------------------------------------------------------------------------
module ppdc_div (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           sq_valid,
  input  ppdc_pkg::sq_t  sq,
  output logic           rec_valid,
  output ppdc_pkg::rec_t rec
);
  import ppdc_pkg::*;

  logic [QW+1:0] v_r;
  dv_t           st_r [0:QW];
  dv_t           first;
  rec_t          rec_r, rec_nxt;

  always_comb begin
    logic [NW-1:0] num;
    first.dist_res = sq.root;
    first.zero     = (sq.root == '0);
    first.q        = '0;
    first.neg      = sq.neg;
    first.img      = sq.img;
    first.last     = sq.last;
    for (int k = 0; k < 3; k++) begin
      num = {1'b0, sq.mag[k], CSH'(0)} + NW'(sq.root >> 1);
      first.rem[k] = {1'b0, num[NW-1:QW]};
      first.n[k]   = num[QW-1:0];
    end
  end

  always_comb begin
    rec_nxt.dist_res = st_r[QW].dist_res;
    rec_nxt.img      = st_r[QW].img;
    rec_nxt.last     = st_r[QW].last;
    for (int k = 0; k < 3; k++) begin
      rec_nxt.cosv[k] = cos_fmt(st_r[QW].q[k], st_r[QW].neg[k], st_r[QW].zero);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[QW:0], sq_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r[0] <= first;
      for (int i = 0; i < QW; i++) st_r[i+1] <= div_step(st_r[i]);
      rec_r <= rec_nxt;
    end
  end

  assign rec_valid = v_r[QW+1];
  assign rec       = rec_r;

endmodule

// ===== rtl/periodic_pair_distance_cosines_top.sv =====
// ----------------------------------------------------------------------------
// periodic_pair_distance_cosines_top
// Pair distance under a cutoff with periodic images and direction cosines.
// ----------------------------------------------------------------------------
// A pair beat carries two positions. In open mode the direct offset is tested
// once; in periodic mode all 27 images (x outer, z inner, each d-L, d, d+L)
// are tested side by side, and every image whose squared distance is at most
// cutoff squared gives one output beat, with tlast on the final beat of the
// pair. A pair enters every cycle while the image picker keeps up: the
// picker holds a pair until it has issued every passing image, one image
// per cycle while the output is not stalled, and that sets the sustained rate.
// The first output beat of a pair passes through five window-test stages,
// the picker, the square root entry register and 24 square root stages, an
// offset stage, 17 divider stages and the output register. Configuration
// writes are accepted every cycle and should be made only while the block
// is empty.
module periodic_pair_distance_cosines_top (
  input  logic                          clk,
  input  logic                          rst_n,
  // Configuration write channel.
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ppdc_pkg::CFG_IW-1:0]   cfg_index,
  input  logic [ppdc_pkg::CW-1:0]       cfg_data,
  // Pair input: ax, ay, az, bx, by, bz, 24 bits each, from bit 0 up.
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [ppdc_pkg::IN_W-1:0]     in_tdata,
  // Records: tdata holds dist_res, cos_x, cos_y, cos_z from bit 0 up.
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [ppdc_pkg::OUT_W-1:0]    out_tdata,
  // tuser holds image_x, image_y, image_z, two bits each, from bit 0 up.
  output logic [ppdc_pkg::USER_W-1:0]   out_tuser,
  output logic                          out_tlast
);
  import ppdc_pkg::*;

  cfg_t  cfg_r;
  logic  pair_valid, pair_ready;
  pair_t pair;
  logic  cand_valid;
  cand_t cand;
  logic  sq_valid;
  sq_t   sq;
  logic  rec_valid;
  rec_t  rec;
  logic  en;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_PERIODIC: cfg_r.periodic    <= cfg_data[0];
        REG_CELL_X:   cfg_r.cell_len[0] <= cfg_data;
        REG_CELL_Y:   cfg_r.cell_len[1] <= cfg_data;
        REG_CELL_Z:   cfg_r.cell_len[2] <= cfg_data;
        REG_CUTOFF:   cfg_r.cutoff      <= cfg_data;
        default: ;
      endcase
    end
  end

  // The whole back end advances together whenever the output can move.
  assign en = !rec_valid || out_tready;

  ppdc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .pair_valid (pair_valid),
    .pair_ready (pair_ready),
    .pair       (pair)
  );

  ppdc_pick u_pick (
    .clk        (clk),
    .rst_n      (rst_n),
    .pair_valid (pair_valid),
    .pair_ready (pair_ready),
    .pair       (pair),
    .en         (en),
    .cand_valid (cand_valid),
    .cand       (cand)
  );

  ppdc_sqrt u_sqrt (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .cand_valid (cand_valid),
    .cand       (cand),
    .sq_valid   (sq_valid),
    .sq         (sq)
  );

  ppdc_div u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .sq_valid   (sq_valid),
    .sq         (sq),
    .rec_valid  (rec_valid),
    .rec        (rec)
  );

  assign out_tvalid = rec_valid;
  assign out_tdata  = {rec.cosv[2], rec.cosv[1], rec.cosv[0], rec.dist_res};
  assign out_tuser  = {rec.img[2], rec.img[1], rec.img[0]};
  assign out_tlast  = rec.last;

endmodule

// ===== rtl/ppdc_checker.sv =====
// ----------------------------------------------------------------------------
// ppdc_checker
// Port-level checks on the record stream.
// ----------------------------------------------------------------------------
module ppdc_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_tvalid,
  input logic                        out_tready,
  input logic [ppdc_pkg::OUT_W-1:0]  out_tdata,
  input logic [ppdc_pkg::USER_W-1:0] out_tuser,
  input logic                        out_tlast
);
  import ppdc_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
    $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled record changed");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("record valid after reset");

  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[CW-1:0] == '0 |-> out_tdata[CW +: 3*COSW] == '0)
    else $error("coincident points gave nonzero cosines");

  a_image: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser[1:0] != 2'd3 && out_tuser[3:2] != 2'd3 &&
    out_tuser[5:4] != 2'd3)
    else $error("image selector out of range");

endmodule

bind periodic_pair_distance_cosines_top ppdc_checker u_ppdc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

// ===== tb/periodic_pair_distance_cosines_top_test.sv =====
// ----------------------------------------------------------------------------
// periodic_pair_distance_cosines_top_test
// Self-checking bench for the pair distance and direction cosine pipeline.
// ----------------------------------------------------------------------------
// Pairs of positions are streamed into the block under several register
// settings (open and periodic mode, zero and full-scale cells and cutoffs).
// A predictor written here computes the records each pair should produce,
// and a scoreboard compares every output beat, field by field, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module periodic_pair_distance_cosines_top_test;
  import ppdc_pkg::*;

  typedef struct {
    logic [23:0] dist_res;
    logic [15:0] cosv [3];
    logic [1:0]  img [3];
    logic        last;
  } pair_rec_t;

  // Scoreboard: holds the records still owed by the block and checks beats.
  class pair_scoreboard;
    pair_rec_t pending [$];
    int        errors;
    bit        periodic;
    logic [23:0] cell_len [3];
    logic [23:0] cutoff;

    function new();
      errors = 0;
      periodic = 0;
      cutoff = '0;
      foreach (cell_len[i]) cell_len[i] = '0;
    endfunction

    function logic [63:0] isqrt(logic [63:0] v);
      logic [63:0] r;
      logic [63:0] b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function logic [15:0] cosine(longint off, logic [63:0] dres);
      logic [63:0] m;
      logic [63:0] q;
      if (dres == 0) return '0;
      m = (off < 0) ? -off : off;
      q = (m * 32768 + dres / 2) / dres;
      if (off < 0) begin
        if (q > 32768) q = 32768;
        return 16'(-q);
      end
      if (q > 32767) q = 32767;
      return q[15:0];
    endfunction

    // Tests one image and queues a record when it lies within the cutoff.
    function bit try_image(longint o [3], int ix, int iy, int iz);
      logic [63:0] s;
      logic [63:0] m;
      logic [63:0] d;
      pair_rec_t r;
      s = 0;
      for (int k = 0; k < 3; k++) begin
        m = (o[k] < 0) ? -o[k] : o[k];
        if (m > cutoff) return 0;
        s = s + m * m;   // bounded by cutoff, cannot overflow
      end
      if (s > 64'(cutoff) * cutoff) return 0;
      d = isqrt(s);
      r.dist_res = d[23:0];
      for (int k = 0; k < 3; k++) r.cosv[k] = cosine(o[k], d);
      r.img[0] = 2'(ix); r.img[1] = 2'(iy); r.img[2] = 2'(iz);
      r.last = 0;
      pending.push_back(r);
      return 1;
    endfunction

    // Notes an accepted pair: works out and queues its expected records.
    function void note_pair(logic [23:0] a [3], logic [23:0] b [3]);
      longint dlt [3];
      longint o [3];
      int n;
      n = 0;
      for (int k = 0; k < 3; k++) dlt[k] = longint'(b[k]) - longint'(a[k]);
      if (!periodic) begin
        n = try_image(dlt, 1, 1, 1);
      end else begin
        for (int u = 0; u < 3; u++)
          for (int v = 0; v < 3; v++)
            for (int w = 0; w < 3; w++) begin
              o[0] = dlt[0] + (u - 1) * longint'(cell_len[0]);
              o[1] = dlt[1] + (v - 1) * longint'(cell_len[1]);
              o[2] = dlt[2] + (w - 1) * longint'(cell_len[2]);
              n += try_image(o, u, v, w);
            end
      end
      if (n > 0) pending[$].last = 1;
    endfunction

    function void check_beat(logic [OUT_W-1:0] data, logic [USER_W-1:0] user,
                             logic tlast);
      pair_rec_t e;
      if (pending.size() == 0) begin
        $error("unexpected record beat: tdata %h tuser %h", data, user);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (data[23:0] !== e.dist_res) begin
        $error("dist_res: expected %0d, got %0d", e.dist_res, data[23:0]);
        errors++;
      end
      for (int k = 0; k < 3; k++) begin
        if (data[24 + 16 * k +: 16] !== e.cosv[k]) begin
          $error("cos_%s: expected %0d, got %0d", k == 0 ? "x" : k == 1 ? "y" : "z",
                 $signed(e.cosv[k]), $signed(data[24 + 16 * k +: 16]));
          errors++;
        end
        if (user[2 * k +: 2] !== e.img[k]) begin
          $error("image_%s: expected %0d, got %0d", k == 0 ? "x" : k == 1 ? "y" : "z",
                 e.img[k], user[2 * k +: 2]);
          errors++;
        end
      end
      if (tlast !== e.last) begin
        $error("last: expected %0b, got %0b", e.last, tlast);
        errors++;
      end
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [CFG_IW-1:0] cfg_index;
  logic [CW-1:0]     cfg_data;
  logic              in_tvalid;
  logic              in_tready;
  logic [IN_W-1:0]   in_tdata;    // ax, ay, az, bx, by, bz from bit 0 up
  logic              out_tvalid;
  logic              out_tready;
  logic [OUT_W-1:0]  out_tdata;   // dist_res, cos_x, cos_y, cos_z from bit 0 up
  logic [USER_W-1:0] out_tuser;   // image_x, image_y, image_z from bit 0 up
  logic              out_tlast;

  pair_scoreboard sb;
  int unsigned    cycles;
  int unsigned    stall_mode;
  // This is the drain wait after idle, long enough for the pipeline to empty.
  localparam int unsigned DRAIN = 80;
  // Worst case: 27 records per pair, each behind a long receiver stall.
  localparam int unsigned LIMIT = 2_000_000;

  periodic_pair_distance_cosines_top u_top (.*);

  initial clk = 0;
  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  // Watchdog: a hung handshake must not keep the run alive forever.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // The receiver stalls in one of a few patterns chosen by the stimulus:
  // always ready, random 50 percent, or mostly stalled.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 0;
    end else begin
      case (stall_mode)
        0: out_tready <= 1;
        1: out_tready <= 1'($urandom_range(1, 0));
        default: out_tready <= ($urandom_range(7, 0) == 0);
      endcase
    end
  end

  // Every accepted record beat is checked against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_beat(out_tdata, out_tuser, out_tlast);
  end

  // Drives one register write and returns after its accepting edge; the
  // caller drops cfg_valid after the last write of a group.
  task automatic write_reg(logic [CFG_IW-1:0] idx, logic [CW-1:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_PERIODIC: sb.periodic = val[0];
      REG_CELL_X:   sb.cell_len[0] = val;
      REG_CELL_Y:   sb.cell_len[1] = val;
      REG_CELL_Z:   sb.cell_len[2] = val;
      REG_CUTOFF:   sb.cutoff = val;
      default: ;
    endcase
  endtask

  // Waits until every owed record has come, then for the pipeline to empty,
  // since a pair with no passing image may still be in flight.
  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic set_config(bit per, logic [CW-1:0] cx, logic [CW-1:0] cy,
                            logic [CW-1:0] cz, logic [CW-1:0] rc);
    drain();
    write_reg(REG_PERIODIC, CW'(per));
    write_reg(REG_CELL_X, cx);
    write_reg(REG_CELL_Y, cy);
    write_reg(REG_CELL_Z, cz);
    write_reg(REG_CUTOFF, rc);
    cfg_valid <= 0;
  endtask

  // Sends one pair beat; the scoreboard hears of it at the accepting edge.
  task automatic send_pair(logic [23:0] a [3], logic [23:0] b [3]);
    in_tvalid <= 1;
    in_tdata  <= {b[2], b[1], b[0], a[2], a[1], a[0]};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_pair(a, b);
  endtask

  task automatic idle_gap();
    in_tvalid <= 0;
    repeat ($urandom_range(4, 1)) @(posedge clk);
  endtask

  // Random coordinate: mostly near a center so images land inside the
  // cutoff, sometimes anywhere in the full range.
  function automatic logic [23:0] near(logic [23:0] c, logic [23:0] spread);
    if ($urandom_range(5, 0) == 0) return 24'($urandom);
    return c + 24'($urandom_range(spread, 0));
  endfunction

  task automatic random_pairs(int count, logic [23:0] spread, bit wrap,
                              logic [23:0] cell_len [3]);
    logic [23:0] a [3];
    logic [23:0] b [3];
    int burst;
    burst = 0;
    for (int i = 0; i < count; i++) begin
      for (int k = 0; k < 3; k++) begin
        a[k] = near(24'h10_0000, spread);
        // Near the far side of the cell, so a wrapped image can pass.
        b[k] = wrap && $urandom_range(1, 0)
               ? a[k] + cell_len[k] - 24'($urandom_range(spread, 0))
               : near(a[k], spread);
      end
      send_pair(a, b);
      if (burst == 0) begin
        if ($urandom_range(2, 0) != 0) idle_gap();
        burst = $urandom_range(12, 1);
      end else begin
        burst--;
      end
    end
    in_tvalid <= 0;
  endtask

  logic [23:0] pa [3];
  logic [23:0] pb [3];
  logic [23:0] cl [3];

  initial begin
    sb         = new();
    cycles     = 0;
    stall_mode = 0;
    rst_n      = 0;
    cfg_valid  = 0;
    cfg_index  = '0;
    cfg_data   = '0;
    in_tvalid  = 0;
    in_tdata   = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed part, open mode with the widest cutoff.
    set_config(0, 24'h0, 24'h0, 24'h0, 24'hFF_FFFF);
    foreach (pa[k]) begin pa[k] = 24'h0; pb[k] = 24'h0; end
    send_pair(pa, pb);                     // coincident points, zero cosines
    foreach (pb[k]) pb[k] = 24'hFF_FFFF;
    send_pair(pa, pb);                     // largest offset, all positive
    send_pair(pb, pa);                     // largest offset, all negative
    pb[1] = 24'h0; pb[2] = 24'h0;
    send_pair(pa, pb);                     // one axis only, cosine saturates
    send_pair(pb, pa);                     // one axis negative, full scale
    pa[0] = 24'h12_3456; pa[1] = 24'hAB_CDEF; pa[2] = 24'h55_5555;
    pb[0] = 24'hED_CBA9; pb[1] = 24'h54_3210; pb[2] = 24'hAA_AAAA;
    send_pair(pa, pb);
    in_tvalid <= 0;

    // Zero cutoff: only coincident points pass.
    set_config(0, 24'h0, 24'h0, 24'h0, 24'h0);
    send_pair(pa, pa);
    send_pair(pa, pb);
    in_tvalid <= 0;

    // Periodic with zero cells: every image coincides, 27 duplicates.
    set_config(1, 24'h0, 24'h0, 24'h0, 24'h8_0000);
    foreach (pb[k]) pb[k] = pa[k] + 24'h1_0000;
    send_pair(pa, pb);
    send_pair(pa, pa);
    in_tvalid <= 0;

    // Periodic with full-scale cells and cutoff: many images pass.
    set_config(1, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF);
    foreach (pa[k]) begin pa[k] = 24'h0; pb[k] = 24'hFF_FFFF; end
    send_pair(pa, pb);
    send_pair(pb, pa);
    foreach (pa[k]) begin pa[k] = 24'h7F_FFFF; pb[k] = 24'h80_0000; end
    send_pair(pa, pb);
    in_tvalid <= 0;

    // Random part under several settings and receiver behaviors.
    cl[0] = 24'h0A_0000; cl[1] = 24'h0C_8000; cl[2] = 24'h0B_4000;
    stall_mode = 1;
    set_config(1, cl[0], cl[1], cl[2], 24'h04_0000);
    random_pairs(50, 24'h03_0000, 1, cl);
    stall_mode = 2;
    set_config(0, cl[0], cl[1], cl[2], 24'h06_0000);
    random_pairs(40, 24'h05_0000, 0, cl);
    // Hold off until every owed record has come before the next burst.
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    random_pairs(10, 24'h05_0000, 0, cl);
    stall_mode = 0;
    cl[0] = 24'h03_0000; cl[1] = 24'h02_8000; cl[2] = 24'h03_8000;
    set_config(1, cl[0], cl[1], cl[2], 24'h03_0000);
    random_pairs(30, 24'h02_0000, 1, cl);
    stall_mode = 1;
    cl[0] = 24'($urandom); cl[1] = 24'($urandom); cl[2] = 24'($urandom);
    set_config(1, cl[0], cl[1], cl[2], 24'($urandom));
    random_pairs(30, 24'hFF_FFFF, 1, cl);

    drain();
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
